// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while in reset
`define SPIQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication
`define SPIQ_IMPLIES(label, ante, cons, msg) \
    `SPIQ_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: rtl/spiq_pkg.sv
package spiq_pkg;

    localparam int DEPTH        = 16;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int CNT_BITS     = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_cmd_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic                    out_valid;
        logic [KEY_BITS-1:0]     out_key;
        logic [PAYLOAD_BITS-1:0] out_payload;
        status_t                 status;
        logic                    is_empty;
        logic                    is_full;
    } rsp_t;

endpackage

// File: rtl/spiq_req_if.sv
interface spiq_req_if import spiq_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [1:0]              op;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;

    modport source (output valid, output op, output key, output payload, input ready);
    modport sink (input valid, input op, input key, input payload, output ready);
endinterface

// File: rtl/spiq_rsp_if.sv
interface spiq_rsp_if import spiq_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    out_valid;
    logic [KEY_BITS-1:0]     out_key;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [1:0]              status;
    logic                    is_empty;
    logic                    is_full;

    modport source (
        output valid, output out_valid, output out_key, output out_payload,
        output status, output is_empty, output is_full, input ready
    );
    modport sink (
        input valid, input out_valid, input out_key, input out_payload,
        input status, input is_empty, input is_full, output ready
    );
endinterface

// File: rtl/spiq_cell.sv
module spiq_cell import spiq_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  entry_t    new_ent,
    input  entry_t    left_ent,
    input  entry_t    right_ent,
    input  logic      occ,
    input  logic      fifo_mode,
    output entry_t    ent,
    output logic      pass
);

    entry_t ent_reg;
    entry_t ent_next;

    always_comb
    begin
        case (cmd)
            CELL_LOAD:       ent_next = new_ent;
            CELL_FROM_LEFT:  ent_next = left_ent;
            CELL_FROM_RIGHT: ent_next = right_ent;
            default:         ent_next = ent_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    // new item may go ahead of this cell
    assign pass = !occ || (!fifo_mode && (ent_reg.key > new_ent.key));
    assign ent  = ent_reg;

endmodule

// File: rtl/sorted_insert_priority_queue_top.sv
// channel | dir | beat contents
// req     | in  | op, key, payload
// rsp     | out | out_valid, out_key, out_payload, status, is_empty, is_full
// cfg     | in  | cfg_we, cfg_wdata (fifo_mode)
//
// one request beat is taken per cycle unless rsp stalls; its response is registered and
// appears on rsp the cycle after acceptance
// every cell of the chain compares and shifts in the same cycle
// rsp stalls hold the response register and back-pressure req
// reset empties the queue and clears fifo_mode; no clearing pass
module sorted_insert_priority_queue_top import spiq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    spiq_req_if.sink   req,
    spiq_rsp_if.source rsp,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);

    `include "assert_macros.svh"

    localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                fifo_mode_reg;
    logic                rsp_vld_reg;
    rsp_t                rsp_reg;
    rsp_t                rsp_next;

    logic                accept;
    logic                do_insert;
    logic                do_remove;
    entry_t              new_ent;
    entry_t              ent_arr   [DEPTH];
    entry_t              left_arr  [DEPTH];
    entry_t              right_arr [DEPTH];
    cell_cmd_t           cmd_arr   [DEPTH];
    logic [DEPTH-1:0]    occ_vec;
    logic [DEPTH-1:0]    pass_vec;
    logic [DEPTH-1:0]    slot_vec;

    assign req.ready = !rsp_vld_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign new_ent   = '{key: req.key, payload: req.payload};

    always_comb
    begin
        count_next = count_reg;
        do_insert  = 1'b0;
        do_remove  = 1'b0;
        rsp_next   = '0;
        rsp_next.status = ST_OK;
        case (op_t'(req.op))
            OP_INSERT:
            begin
                if (count_reg == CNT_FULL)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    do_insert  = 1'b1;
                    count_next = count_reg + CNT_ONE;
                end
            end
            OP_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    do_remove            = 1'b1;
                    count_next           = count_reg - CNT_ONE;
                    rsp_next.out_valid   = 1'b1;
                    rsp_next.out_key     = ent_arr[0].key;
                    rsp_next.out_payload = ent_arr[0].payload;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.is_empty = (count_next == '0);
        rsp_next.is_full  = (count_next == CNT_FULL);
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign occ_vec[gi]  = CNT_BITS'(gi) < count_reg;
            // cell and all behind it may move back for the new item
            assign slot_vec[gi] = &pass_vec[DEPTH-1:gi];

            if (gi == 0)
            begin : g_head
                assign left_arr[gi] = new_ent;
                always_comb
                begin
                    if (accept && do_remove)
                        cmd_arr[gi] = CELL_FROM_RIGHT;
                    else if (accept && do_insert && slot_vec[gi])
                        cmd_arr[gi] = CELL_LOAD;
                    else
                        cmd_arr[gi] = CELL_HOLD;
                end
            end
            else
            begin : g_body
                assign left_arr[gi] = ent_arr[gi-1];
                always_comb
                begin
                    if (accept && do_remove)
                        cmd_arr[gi] = CELL_FROM_RIGHT;
                    else if (accept && do_insert && slot_vec[gi] && slot_vec[gi-1])
                        cmd_arr[gi] = CELL_FROM_LEFT;
                    else if (accept && do_insert && slot_vec[gi])
                        cmd_arr[gi] = CELL_LOAD;
                    else
                        cmd_arr[gi] = CELL_HOLD;
                end
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_arr[gi] = ent_arr[gi];
            end
            else
            begin : g_inner
                assign right_arr[gi] = ent_arr[gi+1];
            end

            spiq_cell u_cell (
                .clk       (clk),
                .cmd       (cmd_arr[gi]),
                .new_ent   (new_ent),
                .left_ent  (left_arr[gi]),
                .right_ent (right_arr[gi]),
                .occ       (occ_vec[gi]),
                .fifo_mode (fifo_mode_reg),
                .ent       (ent_arr[gi]),
                .pass      (pass_vec[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fifo_mode_reg <= 1'b0;
            rsp_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                fifo_mode_reg <= cfg_wdata;
            if (accept)
            begin
                count_reg   <= count_next;
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign rsp.valid       = rsp_vld_reg;
    assign rsp.out_valid   = rsp_reg.out_valid;
    assign rsp.out_key     = rsp_reg.out_key;
    assign rsp.out_payload = rsp_reg.out_payload;
    assign rsp.status      = rsp_reg.status;
    assign rsp.is_empty    = rsp_reg.is_empty;
    assign rsp.is_full     = rsp_reg.is_full;

    `SPIQ_ASSERT(a_count_range, count_reg <= CNT_FULL, "item count beyond depth")
    `SPIQ_IMPLIES(a_remove_count, accept && do_remove,
        count_reg == $past(count_reg) - CNT_ONE, "remove did not drop count")
    `SPIQ_IMPLIES(a_fifo_first, accept && do_insert && count_reg == '0,
        ent_arr[0].key == $past(req.key), "insert into empty queue lost key")
    `SPIQ_IMPLIES(a_rsp_after_accept, accept, rsp_vld_reg, "accepted beat left no response")

endmodule

// File: test/testbench.sv
module testbench import spiq_pkg::*;;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 300000;

    localparam rsp_t R_MISS       = {1'b0, 16'h0000, 32'h0000_0000, ST_EMPTY, 1'b1, 1'b0};
    localparam rsp_t R_IDLE_EMPTY = {1'b0, 16'h0000, 32'h0000_0000, ST_OK, 1'b1, 1'b0};
    localparam rsp_t R_HELD       = {1'b0, 16'h0000, 32'h0000_0000, ST_OK, 1'b0, 1'b0};
    localparam rsp_t R_REFUSED    = {1'b0, 16'h0000, 32'h0000_0000, ST_FULL, 1'b0, 1'b1};
    localparam rsp_t R_HEAD_ZERO  = {1'b1, 16'h0000, 32'h0000_0000, ST_OK, 1'b0, 1'b0};
    localparam rsp_t R_HEAD_TOP   = {1'b1, 16'hFFFF, 32'hFFFF_FFFF, ST_OK, 1'b1, 1'b0};

    typedef struct packed {
        logic                    fifo;
        logic [1:0]              op;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] pay;
        logic [4:0]              reps;
        logic                    typed;
        rsp_t                    want;
    } script_row_t;

    // typed rows carry their own response, the rest go through the queue model
    script_row_t script [24] = '{
        '{1'b0, OP_REMOVE, 16'h0000, 32'h0000_0000, 5'd1,  1'b1, R_MISS},
        '{1'b0, OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 5'd1,  1'b1, R_IDLE_EMPTY},
        '{1'b0, OP_CLEAR,  16'h0000, 32'h0000_0000, 5'd1,  1'b1, R_IDLE_EMPTY},
        '{1'b0, OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 5'd1,  1'b1, R_HELD},
        '{1'b0, OP_INSERT, 16'h0000, 32'h0000_0000, 5'd1,  1'b1, R_HELD},
        '{1'b0, OP_INSERT, 16'h0008, 32'hA5A5_A5A5, 5'd1,  1'b0, R_HELD},
        '{1'b0, OP_INSERT, 16'h0008, 32'h5A5A_5A5A, 5'd1,  1'b0, R_HELD},
        '{1'b0, OP_REMOVE, 16'h0000, 32'h0000_0000, 5'd1,  1'b1, R_HEAD_ZERO},
        '{1'b0, OP_REMOVE, 16'h1234, 32'h0000_0000, 5'd1,  1'b0, R_HELD},
        '{1'b0, OP_REMOVE, 16'h0000, 32'h0000_0000, 5'd1,  1'b0, R_HELD},
        '{1'b0, OP_REMOVE, 16'h0000, 32'h0000_0000, 5'd1,  1'b1, R_HEAD_TOP},
        '{1'b0, OP_INSERT, 16'h0007, 32'h0000_0100, 5'd15, 1'b0, R_HELD},
        '{1'b0, OP_INSERT, 16'h0003, 32'h0000_0300, 5'd1,  1'b0, R_HELD},
        '{1'b0, OP_INSERT, 16'h0000, 32'h0000_0000, 5'd1,  1'b1, R_REFUSED},
        '{1'b0, OP_REMOVE, 16'h0000, 32'h0000_0000, 5'd1,  1'b0, R_HELD},
        '{1'b1, OP_INSERT, 16'h0000, 32'hC0FF_EE00, 5'd1,  1'b0, R_HELD},
        '{1'b0, OP_REMOVE, 16'h0000, 32'h0000_0000, 5'd1,  1'b0, R_HELD},
        '{1'b0, OP_INSERT, 16'h0005, 32'h0000_0500, 5'd1,  1'b0, R_HELD},
        '{1'b0, OP_REMOVE, 16'h0000, 32'h0000_0000, 5'd1,  1'b0, R_HELD},
        '{1'b0, OP_CLEAR,  16'hFFFF, 32'hFFFF_FFFF, 5'd1,  1'b1, R_IDLE_EMPTY},
        '{1'b1, OP_INSERT, 16'h0009, 32'h0000_0001, 5'd1,  1'b0, R_HELD},
        '{1'b1, OP_INSERT, 16'h0002, 32'h0000_0002, 5'd1,  1'b0, R_HELD},
        '{1'b1, OP_REMOVE, 16'h0000, 32'h0000_0000, 5'd1,  1'b0, R_HELD},
        '{1'b1, OP_REMOVE, 16'h0000, 32'h0000_0000, 5'd1,  1'b0, R_HELD}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    spiq_req_if req_ch ();
    spiq_rsp_if rsp_ch ();

    sorted_insert_priority_queue_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // queue model
    logic [KEY_BITS-1:0]     pq_key [DEPTH];
    logic [PAYLOAD_BITS-1:0] pq_pay [DEPTH];
    int                      pq_count = 0;
    logic                    pq_fifo = 1'b0;

    rsp_t pending_rsp [$];
    int   mismatches = 0;
    int   cycles = 0;
    int   idle_pct = 9;
    bit   mode_now = 1'b0;
    bit   cur_typed;
    rsp_t cur_want;

    function automatic rsp_t apply_to_queue(logic [1:0] op, logic [KEY_BITS-1:0] key,
                                            logic [PAYLOAD_BITS-1:0] pay);
        rsp_t r;
        int   pos;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_INSERT:
            begin
                if (pq_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    pos = pq_count;
                    if (!pq_fifo)
                    begin
                        while (pos > 0 && pq_key[pos-1] > key)
                        begin
                            pq_key[pos] = pq_key[pos-1];
                            pq_pay[pos] = pq_pay[pos-1];
                            pos--;
                        end
                    end
                    pq_key[pos] = key;
                    pq_pay[pos] = pay;
                    pq_count++;
                end
            end
            OP_REMOVE:
            begin
                if (pq_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.out_valid   = 1'b1;
                    r.out_key     = pq_key[0];
                    r.out_payload = pq_pay[0];
                    for (int i = 0; i + 1 < pq_count; i++)
                    begin
                        pq_key[i] = pq_key[i+1];
                        pq_pay[i] = pq_pay[i+1];
                    end
                    pq_count--;
                end
            end
            OP_CLEAR:
            begin
                pq_count = 0;
            end
            default:
            begin
            end
        endcase
        r.is_empty = (pq_count == 0);
        r.is_full  = (pq_count >= DEPTH);
        return r;
    endfunction

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    // responses are checked before new beats are modelled, as each response is registered after its request
    always @(posedge clk)
    begin
        rsp_t oldest;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t: response beat expected none, got key %0h payload %0h",
                             $time, rsp_ch.out_key, rsp_ch.out_payload);
                    mismatches++;
                end
                else
                begin
                    oldest = pending_rsp.pop_front();
                    check_field("out_valid", 64'(oldest.out_valid), 64'(rsp_ch.out_valid));
                    check_field("out_key", 64'(oldest.out_key), 64'(rsp_ch.out_key));
                    check_field("out_payload", 64'(oldest.out_payload),
                                64'(rsp_ch.out_payload));
                    check_field("status", 64'(oldest.status), 64'(rsp_ch.status));
                    check_field("is_empty", 64'(oldest.is_empty), 64'(rsp_ch.is_empty));
                    check_field("is_full", 64'(oldest.is_full), 64'(rsp_ch.is_full));
                end
            end
            if (cfg_we)
            begin
                pq_fifo = cfg_wdata;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                oldest = apply_to_queue(req_ch.op, req_ch.key, req_ch.payload);
                pending_rsp.push_back(cur_typed ? cur_want : oldest);
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_request(logic [1:0] op, logic [KEY_BITS-1:0] key,
                                logic [PAYLOAD_BITS-1:0] pay, bit typed, rsp_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.op      <= op;
        req_ch.key     <= key;
        req_ch.payload <= pay;
        cur_typed      <= typed;
        cur_want       <= want;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic wait_responses();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_rsp.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    task automatic write_fifo_mode(bit value);
        wait_responses();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        mode_now = value;
    endtask

    initial
    begin
        int                      ins_pct;
        int                      pick;
        logic [1:0]              op;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] pay;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.op      = OP_INSERT;
        req_ch.key     = '0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        cur_typed      = 1'b0;
        cur_want       = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            if (script[i].fifo != mode_now)
            begin
                write_fifo_mode(script[i].fifo);
            end
            for (int j = 0; j < script[i].reps; j++)
            begin
                send_request(script[i].op, script[i].key, PAYLOAD_BITS'(script[i].pay + j),
                             script[i].typed, script[i].want);
            end
        end

        // random phases, each with its own mode and one of three op mixes; all share one key spread
        for (int p = 0; p < 11; p++)
        begin
            write_fifo_mode(p < 2 ? bit'(p) : bit'($urandom_range(1)));
            idle_pct = (p == 4) ? 0 : 9;
            ins_pct  = (p % 3 == 0) ? 35 : (p % 3 == 1) ? 50 : 70;
            for (int n = 0; n < 150; n++)
            begin
                if (p == 6 && n == 75)
                begin
                    wait_responses();
                end
                pick = int'($urandom_range(99));
                if (pick < ins_pct)
                    op = OP_INSERT;
                else if (pick < 95)
                    op = OP_REMOVE;
                else if (pick < 98)
                    op = OP_CLEAR;
                else
                    op = OP_UNUSED;
                pick = int'($urandom_range(9));
                if (pick == 0)
                    key = '0;
                else if (pick == 1)
                    key = '1;
                else if (pick < 5)
                    key = KEY_BITS'($urandom_range(7));
                else
                    key = KEY_BITS'($urandom_range(16'hFFFF));
                pay = $urandom;
                send_request(op, key, pay, 1'b0, '0);
            end
        end

        wait_responses();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
